@@ sv/tss_pkg.sv @@
// Package: shared constants and types for the timer slot scheduler.
package tss_pkg;
  localparam int TIMER_SLOTS_DEF = 16;
  localparam int TIME_W = 48;
  localparam int ACTOR_W = 16;
  localparam int DELAY_W = 31;
  localparam int HANDLE_W = 32;
  localparam int RK_W = 3;
  localparam int CNT_W = 5;

  localparam logic [1:0] KIND_TICK = 2'd0;
  localparam logic [1:0] KIND_ARM1 = 2'd1;
  localparam logic [1:0] KIND_ARMP = 2'd2;
  localparam logic [1:0] KIND_CANCEL = 2'd3;

  localparam logic [RK_W-1:0] RK_FIRED = 3'd0;
  localparam logic [RK_W-1:0] RK_ARMED = 3'd1;
  localparam logic [RK_W-1:0] RK_FULL = 3'd2;
  localparam logic [RK_W-1:0] RK_CANCEL = 3'd3;
  localparam logic [RK_W-1:0] RK_TICK = 3'd4;

  typedef struct packed {
    logic [1:0]          kind;
    logic [TIME_W-1:0]   time_now;
    logic [ACTOR_W-1:0]  actor_id;
    logic [DELAY_W-1:0]  delay;
    logic [HANDLE_W-1:0] target_handle;
  } cmd_t;

  typedef struct packed {
    logic [RK_W-1:0]     result_kind;
    logic [ACTOR_W-1:0]  actor_out;
    logic [HANDLE_W-1:0] handle_out;
    logic                found;
    logic [CNT_W-1:0]    fired_count;
    logic                last;
  } res_t;
endpackage

@@ sv/tss_cmd_fifo.sv @@
// Module: short command queue between front end and slot engine.
module tss_cmd_fifo #(
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  tss_pkg::cmd_t wdata,
  output logic          full,
  input  logic          rd,
  output tss_pkg::cmd_t rdata,
  output logic          empty
);
  localparam int AW = $clog2(DEPTH);
  tss_pkg::cmd_t mem [DEPTH];
  logic [AW-1:0] wp, rp;
  logic [AW:0] cnt;

  assign full = (cnt == (AW+1)'(DEPTH));
  assign empty = (cnt == '0);
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (wr && !full) mem[wp] <= wdata;
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (wr && !full) wp <= (wp == AW'(DEPTH-1)) ? '0 : wp + 1'b1;
      if (rd && !empty) rp <= (rp == AW'(DEPTH-1)) ? '0 : rp + 1'b1;
      cnt <= cnt + (AW+1)'(wr && !full) - (AW+1)'(rd && !empty);
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= (AW+1)'(DEPTH)) else $error("fifo count overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    (empty && !(wr && !full)) |=> empty) else $error("fifo underflow");
  a_fill: assert property (@(posedge clk) disable iff (rst)
    (wr && !full && !(rd && !empty)) |=> !empty) else $error("fifo lost word");
`endif
endmodule

@@ sv/tss_engine.sv @@
// Module: slot table engine; executes arm, cancel and tick, one slot per cycle.
module tss_engine #(
  parameter int SLOTS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  input  tss_pkg::cmd_t cmd,
  output logic          cmd_take,
  output logic          res_valid,
  output tss_pkg::res_t res,
  input  logic          res_take
);
  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int TW = tss_pkg::TIME_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_PICK = 3'd2;
  localparam logic [2:0] ST_FIRE = 3'd3;
  localparam logic [2:0] ST_OUT = 3'd4;

  logic [2:0] state;
  logic [SLOTS-1:0] valid, due;
  logic [TW-1:0] expiry [SLOTS];
  logic [tss_pkg::DELAY_W-1:0] interval [SLOTS];
  logic [tss_pkg::ACTOR_W-1:0] actor [SLOTS];
  logic [tss_pkg::HANDLE_W-1:0] handle [SLOTS];
  logic [tss_pkg::HANDLE_W-1:0] next_handle;

  tss_pkg::cmd_t cur;
  logic [IW-1:0] idx, best;
  logic best_ok;
  logic [TW-1:0] best_exp;
  logic [tss_pkg::CNT_W-1:0] n;
  logic out_tick_done;

  logic [TW:0] sum_arm, sum_rel;
  logic [TW-1:0] arm_exp, rel_exp;
  logic last_idx;
  logic cancel_hit;

  function automatic tss_pkg::res_t mk_res(input logic [tss_pkg::RK_W-1:0] k,
                                           input logic [tss_pkg::ACTOR_W-1:0] a,
                                           input logic [tss_pkg::HANDLE_W-1:0] h,
                                           input logic f,
                                           input logic [tss_pkg::CNT_W-1:0] c,
                                           input logic l);
    mk_res = '{result_kind: k, actor_out: a, handle_out: h, found: f,
               fired_count: c, last: l};
  endfunction

  assign sum_arm = {1'b0, cur.time_now} + (TW+1)'(cur.delay);
  assign arm_exp = sum_arm[TW] ? '1 : sum_arm[TW-1:0];
  assign sum_rel = {1'b0, cur.time_now} + (TW+1)'(interval[best]);
  assign rel_exp = sum_rel[TW] ? '1 : sum_rel[TW-1:0];
  assign last_idx = (idx == IW'(SLOTS-1));
  assign cancel_hit = valid[idx] && (handle[idx] == cur.target_handle);

  assign cmd_take = (state == ST_IDLE) && cmd_valid;
  assign res_valid = (state == ST_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      valid <= '0;
      next_handle <= 32'd1;
      due <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            cur <= cmd;
            idx <= '0;
            n <= '0;
            best_ok <= 1'b0;
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // walk slots one a cycle
          if (cur.kind == tss_pkg::KIND_TICK) begin
            due[idx] <= valid[idx] && (expiry[idx] <= cur.time_now);
            if (last_idx) begin
              idx <= '0;
              best_ok <= 1'b0;
              state <= ST_PICK;
            end else idx <= idx + 1'b1;
          end else if (cur.kind == tss_pkg::KIND_CANCEL) begin
            res <= mk_res(tss_pkg::RK_CANCEL, '0, cur.target_handle, cancel_hit, '0, 1'b1);
            if (cancel_hit) begin
              valid[idx] <= 1'b0;
              state <= ST_OUT;
            end else if (last_idx) state <= ST_OUT;
            else idx <= idx + 1'b1;
          end else begin
            if (!valid[idx]) begin
              valid[idx] <= 1'b1;
              expiry[idx] <= arm_exp;
              interval[idx] <= (cur.kind == tss_pkg::KIND_ARMP) ? cur.delay : '0;
              actor[idx] <= cur.actor_id;
              handle[idx] <= next_handle;
              next_handle <= (next_handle == '1) ? 32'd1 : next_handle + 1'b1;
              res <= mk_res(tss_pkg::RK_ARMED, '0, next_handle, 1'b0, '0, 1'b1);
              state <= ST_OUT;
            end else if (last_idx) begin
              res <= mk_res(tss_pkg::RK_FULL, '0, '0, 1'b0, '0, 1'b1);
              state <= ST_OUT;
            end else idx <= idx + 1'b1;
          end
        end
        ST_PICK: begin
          // earliest due slot; strict compare keeps lowest index on ties
          if (due[idx] && (!best_ok || expiry[idx] < best_exp)) begin
            best <= idx;
            best_exp <= expiry[idx];
            best_ok <= 1'b1;
          end
          if (last_idx) state <= ST_FIRE;
          else idx <= idx + 1'b1;
        end
        ST_FIRE: begin
          idx <= '0;
          if (best_ok) begin
            due[best] <= 1'b0;
            res <= mk_res(tss_pkg::RK_FIRED, actor[best], handle[best], 1'b0, '0, 1'b0);
            n <= n + 1'b1;
            if (interval[best] != '0) expiry[best] <= rel_exp;
            else valid[best] <= 1'b0;
            out_tick_done <= 1'b0;
          end else begin
            res <= mk_res(tss_pkg::RK_TICK, '0, '0, 1'b0, n, 1'b1);
            out_tick_done <= 1'b1;
          end
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (res_take) begin
            best_ok <= 1'b0;
            if (cur.kind == tss_pkg::KIND_TICK && !out_tick_done) state <= ST_PICK;
            else state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    cmd_take |=> state == ST_SCAN) else $error("command taken outside idle");
  a_handle_nz: assert property (@(posedge clk) disable iff (rst)
    next_handle != '0) else $error("zero handle");
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_take) |=> res_valid && $stable(res)) else $error("result lost");
`endif
endmodule

@@ sv/timer_slot_scheduler_unit.sv @@
// Top level: timer slot scheduler with command queue and slot engine.
// Usage:
//  Input channel is a queue write side: drive the word on kind, time_now,
//  actor_id, delay and target_handle with push; it is taken when full is
//  low. A two-entry command queue lets the caller post words while the
//  slot engine is still busy with an earlier one.
//  Result channel is a queue read side: while empty is low the pending
//  result word is on the result ports; pop takes it.
//  Timing: the engine walks the slot table one slot per cycle.
//  Arm walks the table until a free slot, cancel until a matching handle,
//  each at most up to the last slot, then the result is handed off. A tick
//  first walks the table to take its due set, then makes one more pick walk
//  over it for each fired timer and for the closing tick-done word; each
//  pick walk finds the earliest due slot.
//  Stall: a result word held by a missing pop stops the engine; the
//  queue then fills and raises full. Nothing is dropped.
//  Reset (rst, synchronous): all slots invalid, next handle one, queue empty.
module timer_slot_scheduler_unit #(
  parameter int TIMER_SLOTS = tss_pkg::TIMER_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  kind,
  input  logic [47:0] time_now,
  input  logic [15:0] actor_id,
  input  logic [30:0] delay,
  input  logic [31:0] target_handle,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  result_kind,
  output logic [15:0] actor_out,
  output logic [31:0] handle_out,
  output logic        found,
  output logic [4:0]  fired_count,
  output logic        last
);
  tss_pkg::cmd_t in_word, q_word;
  tss_pkg::res_t res;
  logic q_empty, q_take, res_valid;

  assign in_word = '{kind: kind, time_now: time_now, actor_id: actor_id,
                     delay: delay, target_handle: target_handle};

  tss_cmd_fifo #(.DEPTH(2)) u_fifo (
    .clk(clk), .rst(rst), .wr(push), .wdata(in_word), .full(full),
    .rd(q_take), .rdata(q_word), .empty(q_empty)
  );

  tss_engine #(.SLOTS(TIMER_SLOTS)) u_eng (
    .clk(clk), .rst(rst), .cmd_valid(!q_empty), .cmd(q_word), .cmd_take(q_take),
    .res_valid(res_valid), .res(res), .res_take(pop)
  );

  assign empty = !res_valid;
  assign result_kind = res.result_kind;
  assign actor_out = res.actor_out;
  assign handle_out = res.handle_out;
  assign found = res.found;
  assign fired_count = res.fired_count;
  assign last = res.last;
endmodule
